### src/rcfd_pkg.sv
// shared types, constants and the crc byte step for the frame deframer
package rcfd_pkg;

  localparam int FRAME_BYTES = 24;
  localparam int CRC_BYTES   = FRAME_BYTES - 2;
  localparam int FILL_W      = $clog2(FRAME_BYTES + 1);
  localparam int CNT_W       = $clog2(FRAME_BYTES);

  localparam logic [7:0]  SYNC_FIRST   = 8'h5A;
  localparam logic [7:0]  SYNC_SECOND  = 8'hA5;
  localparam logic [7:0]  VERSION_CODE = 8'h01;
  localparam logic [7:0]  LENGTH_CODE  = 8'd24;
  localparam logic [15:0] CRC_INIT     = 16'hFFFF;
  localparam logic [15:0] CRC_POLY     = 16'hA001;

  typedef struct packed {
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [15:0]        sequence_res;
    logic [31:0]        tick_ms;
    logic signed [15:0] left_x;
    logic signed [15:0] left_y;
    logic signed [15:0] right_x;
    logic signed [15:0] right_y;
    logic [7:0]         switch_left;
    logic [7:0]         switch_right;
    logic [15:0]        spare_word;
    logic [31:0]        reject_count;
    logic [31:0]        discard_count;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctrl_t;

  typedef struct packed {
    logic init;
    logic update;
  } crc_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CRC,
    ST_DONE
  } state_t;

  // one byte of crc-16/modbus, lsb first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

### src/rcfd_stream_if.sv
// valid/ready stream channel carrying one item per handshake
interface rcfd_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### src/rcfd_cell.sv
// one byte cell of the window chain: load a received byte or take the neighbor's byte
module rcfd_cell (
  input  logic                  clk,
  input  rcfd_pkg::cell_ctrl_t  ctrl,
  input  logic [7:0]            load_byte,
  input  logic [7:0]            next_byte,
  output logic [7:0]            q
);

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      q <= load_byte;
    end else if (ctrl.shift) begin
      q <= next_byte;
    end
  end

endmodule

### src/rcfd_crc.sv
// byte-serial crc-16/modbus accumulator
module rcfd_crc (
  input  logic                 clk,
  input  rcfd_pkg::crc_ctrl_t  ctrl,
  input  logic [7:0]           data,
  output logic [15:0]          crc
);

  always_ff @(posedge clk) begin
    if (ctrl.init) begin
      crc <= rcfd_pkg::CRC_INIT;
    end else if (ctrl.update) begin
      crc <= rcfd_pkg::crc_byte(crc, data);
    end
  end

endmodule

### src/rc_frame_deframer_crc16.sv
// top level: sync-word frame deframer with crc-16/modbus check
// Received bytes fill a chain of 24 byte cells; a byte that does not complete the window
// is taken directly while idle. The byte that fills the window starts a pass on the chain:
// while the front is not the 5A A5 sync pair the chain shifts one byte per cycle (each
// shifted byte counted as dropped); with the pair in front of a full window and a good
// version and length, the chain rotates once around feeding the byte-serial crc unit,
// and the done state then emits the frame or drops one byte. No new byte is taken until
// the pass ends. Decoded frames wait in an output register, so bytes keep flowing while a
// frame is not yet taken; only a second frame waits for it.
module rc_frame_deframer_crc16 (
  input  logic         clk,
  input  logic         rst,
  rcfd_stream_if.sink   rx,
  rcfd_stream_if.source frame
);

  localparam int NB = rcfd_pkg::FRAME_BYTES;
  localparam int FW = rcfd_pkg::FILL_W;
  localparam int CW = rcfd_pkg::CNT_W;

  logic [7:0]           cell_q    [NB];
  rcfd_pkg::cell_ctrl_t cell_ctrl [NB];

  rcfd_pkg::state_t     state, state_next;
  logic [FW-1:0]        fill, fill_next;
  logic [CW-1:0]        cnt, cnt_next;
  logic                 crc_ok, crc_ok_next;
  logic [31:0]          invalid_count, invalid_count_next;
  logic [31:0]          dropped_count, dropped_count_next;
  logic                 out_valid, out_valid_next;
  rcfd_pkg::out_item_t  out_data;

  rcfd_pkg::crc_ctrl_t  crc_ctrl;
  logic [15:0]          crc_q;
  logic                 shift_en;
  logic                 load_en;
  logic                 out_load;
  logic                 accept;
  logic                 front_pair;
  logic                 header_ok;

  // cell k takes cell k+1; the last cell takes cell 0 so a full pass rotates the window
  for (genvar k = 0; k < NB; k++) begin : g_cell
    rcfd_cell u_cell (
      .clk       (clk),
      .ctrl      (cell_ctrl[k]),
      .load_byte (rx.data.rx_byte),
      .next_byte (cell_q[(k + 1) % NB]),
      .q         (cell_q[k])
    );
  end

  rcfd_crc u_crc (
    .clk  (clk),
    .ctrl (crc_ctrl),
    .data (cell_q[0]),
    .crc  (crc_q)
  );

  assign rx.ready    = (state == rcfd_pkg::ST_IDLE);
  assign accept      = rx.valid && rx.ready;
  assign frame.valid = out_valid;
  assign frame.data  = out_data;

  assign front_pair = (cell_q[0] == rcfd_pkg::SYNC_FIRST) &&
                      (cell_q[1] == rcfd_pkg::SYNC_SECOND);
  assign header_ok  = (cell_q[2] == rcfd_pkg::VERSION_CODE) &&
                      (cell_q[3] == rcfd_pkg::LENGTH_CODE);

  always_comb begin
    for (int k = 0; k < NB; k++) begin
      cell_ctrl[k].load  = load_en && (fill == FW'(k));
      cell_ctrl[k].shift = shift_en;
    end
  end

  always_comb begin
    state_next         = state;
    fill_next          = fill;
    cnt_next           = cnt;
    crc_ok_next        = crc_ok;
    invalid_count_next = invalid_count;
    dropped_count_next = dropped_count;
    shift_en           = 1'b0;
    load_en            = 1'b0;
    out_load           = 1'b0;
    crc_ctrl           = '0;

    unique case (state)
      rcfd_pkg::ST_IDLE: begin
        if (accept) begin
          load_en   = 1'b1;
          fill_next = fill + FW'(1);
          if (fill == FW'(NB - 1)) begin
            state_next = rcfd_pkg::ST_SCAN;
          end
        end
      end

      rcfd_pkg::ST_SCAN: begin
        priority if (front_pair) begin
          if (fill == FW'(NB)) begin
            if (header_ok) begin
              crc_ctrl.init = 1'b1;
              cnt_next      = '0;
              state_next    = rcfd_pkg::ST_CRC;
            end else begin
              invalid_count_next = invalid_count + 32'd1;
              dropped_count_next = dropped_count + 32'd1;
              shift_en           = 1'b1;
              fill_next          = fill - FW'(1);
              state_next         = rcfd_pkg::ST_IDLE;
            end
          end else begin
            state_next = rcfd_pkg::ST_IDLE;
          end
        end else if (fill > FW'(1)) begin
          shift_en           = 1'b1;
          fill_next          = fill - FW'(1);
          dropped_count_next = dropped_count + 32'd1;
        end else begin
          // a lone trailing 5A stays as a possible start of the next pair
          state_next = rcfd_pkg::ST_IDLE;
          if (cell_q[0] != rcfd_pkg::SYNC_FIRST) begin
            fill_next          = '0;
            dropped_count_next = dropped_count + 32'd1;
          end
        end
      end

      rcfd_pkg::ST_CRC: begin
        shift_en = 1'b1;
        if (cnt < CW'(rcfd_pkg::CRC_BYTES)) begin
          crc_ctrl.update = 1'b1;
        end
        if (cnt == CW'(rcfd_pkg::CRC_BYTES)) begin
          crc_ok_next = (crc_q == {cell_q[1], cell_q[0]});
        end
        if (cnt == CW'(NB - 1)) begin
          state_next = rcfd_pkg::ST_DONE;
        end else begin
          cnt_next = cnt + CW'(1);
        end
      end

      rcfd_pkg::ST_DONE: begin
        if (crc_ok) begin
          if (!out_valid || frame.ready) begin
            out_load   = 1'b1;
            fill_next  = '0;
            state_next = rcfd_pkg::ST_IDLE;
          end
        end else begin
          invalid_count_next = invalid_count + 32'd1;
          dropped_count_next = dropped_count + 32'd1;
          shift_en           = 1'b1;
          fill_next          = fill - FW'(1);
          state_next         = rcfd_pkg::ST_IDLE;
        end
      end
    endcase

    out_valid_next = out_load || (out_valid && !frame.ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= rcfd_pkg::ST_IDLE;
      fill          <= '0;
      cnt           <= '0;
      crc_ok        <= 1'b0;
      invalid_count <= '0;
      dropped_count <= '0;
      out_valid     <= 1'b0;
    end else begin
      state         <= state_next;
      fill          <= fill_next;
      cnt           <= cnt_next;
      crc_ok        <= crc_ok_next;
      invalid_count <= invalid_count_next;
      dropped_count <= dropped_count_next;
      out_valid     <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.sequence_res  <= {cell_q[5], cell_q[4]};
      out_data.tick_ms       <= {cell_q[9], cell_q[8], cell_q[7], cell_q[6]};
      out_data.left_x        <= {cell_q[11], cell_q[10]};
      out_data.left_y        <= {cell_q[13], cell_q[12]};
      out_data.right_x       <= {cell_q[15], cell_q[14]};
      out_data.right_y       <= {cell_q[17], cell_q[16]};
      out_data.switch_left   <= cell_q[18];
      out_data.switch_right  <= cell_q[19];
      out_data.spare_word    <= {cell_q[21], cell_q[20]};
      out_data.reject_count  <= invalid_count;
      out_data.discard_count <= dropped_count;
    end
  end

endmodule
